// ===== hw/rtl/atrp_pkg.sv =====
// shared types, constants and angle table functions for the tilt core
package atrp_pkg;

    localparam int ACCEL_W = 16;
    localparam int ROLL_W = 15;
    localparam int PITCH_W = 14;
    localparam int GUARD_SHIFT = 20;
    localparam int DATA_W = 40;
    localparam int ACC_W = 42;
    localparam int GAIN_W = 24;
    localparam int GAIN_SHIFT = 24;
    localparam logic [GAIN_W-1:0] INV_GAIN_Q24 = 24'd10188014;
    localparam logic [63:0] DEG_PER_RAD_Q26 = 64'd3845054675;
    localparam logic signed [ACC_W-1:0] DEG180_Q32 = ACC_W'(64'd180 << 32);
    localparam logic signed [ACC_W-1:0] DEG90_Q32 = ACC_W'(64'd90 << 32);

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic signed [ACC_W-1:0] acc_t;

    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[62:0], num[b]};
            if (r >= den)
            begin
                r = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(2^-i) in degrees, q32
    function automatic logic [63:0] stage_angle(input int i);
        logic [63:0] sum;
        logic [63:0] term;
        logic minus;
        sum = '0;
        minus = 1'b0;
        if (i == 0)
        begin
            return 64'd45 << 32;
        end
        for (int n = 1; i * n < 62; n += 2)
        begin
            term = udiv64(64'd1 << (62 - i * n), 64'(n));
            if (minus)
            begin
                sum = sum - term;
            end
            else
            begin
                sum = sum + term;
            end
            minus = !minus;
        end
        return ((sum >> 30) * DEG_PER_RAD_Q26) >> 26;
    endfunction

endpackage

// ===== hw/rtl/atrp_if.sv =====
// request channel interfaces for samples and angle results
interface atrp_in_if;
    logic valid;
    logic ready;
    logic signed [atrp_pkg::ACCEL_W-1:0] accel_x;
    logic signed [atrp_pkg::ACCEL_W-1:0] accel_y;
    logic signed [atrp_pkg::ACCEL_W-1:0] accel_z;
    modport source (output valid, accel_x, accel_y, accel_z, input ready);
    modport sink (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface atrp_out_if;
    logic valid;
    logic ready;
    logic signed [atrp_pkg::ROLL_W-1:0] roll_angle;
    logic signed [atrp_pkg::PITCH_W-1:0] pitch_angle;
    modport source (output valid, roll_angle, pitch_angle, input ready);
    modport sink (input valid, roll_angle, pitch_angle, output ready);
endinterface

// ===== hw/rtl/atrp_cordic_vec.sv =====
// pipelined vectoring cordic pass with half plane prerotation
module atrp_cordic_vec #(
    parameter int STAGES = 16,
    parameter int SB_W = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  atrp_pkg::data_t    in_x,
    input  atrp_pkg::data_t    in_y,
    input  logic [SB_W-1:0]    in_sb,
    output logic               out_valid,
    output atrp_pkg::data_t    out_x,
    output atrp_pkg::acc_t     out_acc,
    output logic [SB_W-1:0]    out_sb
);

    logic [STAGES:0] v_reg;
    atrp_pkg::data_t x_reg [0:STAGES];
    atrp_pkg::data_t y_reg [0:STAGES];
    atrp_pkg::acc_t a_reg [0:STAGES];
    logic [STAGES:0] z_reg;
    logic [SB_W-1:0] sb_reg [0:STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[STAGES-1:0], in_valid};
        end
    end

    // prerotation
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z_reg[0] <= (in_x == '0) && (in_y == '0);
            sb_reg[0] <= in_sb;
            if (in_x < 0)
            begin
                x_reg[0] <= -in_x;
                y_reg[0] <= -in_y;
                a_reg[0] <= (in_y >= 0) ? atrp_pkg::DEG180_Q32 : -atrp_pkg::DEG180_Q32;
            end
            else
            begin
                x_reg[0] <= in_x;
                y_reg[0] <= in_y;
                a_reg[0] <= '0;
            end
        end
    end

    for (genvar k = 0; k < STAGES; k++)
    begin : g_stage
        localparam atrp_pkg::acc_t ANG = atrp_pkg::ACC_W'(atrp_pkg::stage_angle(k));
        atrp_pkg::data_t xs;
        atrp_pkg::data_t ys;
        atrp_pkg::data_t x_next;
        atrp_pkg::data_t y_next;
        atrp_pkg::acc_t a_next;

        always_comb
        begin
            xs = x_reg[k] >>> k;
            ys = y_reg[k] >>> k;
            if (y_reg[k] >= 0)
            begin
                x_next = x_reg[k] + ys;
                y_next = y_reg[k] - xs;
                a_next = a_reg[k] + ANG;
            end
            else
            begin
                x_next = x_reg[k] - ys;
                y_next = y_reg[k] + xs;
                a_next = a_reg[k] - ANG;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[k+1] <= x_next;
                y_reg[k+1] <= y_next;
                a_reg[k+1] <= a_next;
                z_reg[k+1] <= z_reg[k];
                sb_reg[k+1] <= sb_reg[k];
            end
        end
    end

    assign out_valid = v_reg[STAGES];
    assign out_x = z_reg[STAGES] ? '0 : x_reg[STAGES];
    assign out_acc = z_reg[STAGES] ? '0 : a_reg[STAGES];
    assign out_sb = sb_reg[STAGES];

endmodule

// ===== hw/rtl/atrp_mag_scale.sv =====
// cordic gain removal on the magnitude, one multiply stage
module atrp_mag_scale #(
    parameter int SB_W = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  atrp_pkg::data_t    in_mag,
    input  logic [SB_W-1:0]    in_sb,
    output logic               out_valid,
    output atrp_pkg::data_t    out_mag,
    output logic [SB_W-1:0]    out_sb
);

    localparam int PROD_W = atrp_pkg::DATA_W - 1 + atrp_pkg::GAIN_W;

    logic valid_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [SB_W-1:0] sb_reg;
    logic [atrp_pkg::DATA_W-2:0] mag_pos;

    assign mag_pos = (in_mag < 0) ? '0 : in_mag[atrp_pkg::DATA_W-2:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= PROD_W'(mag_pos) * PROD_W'(atrp_pkg::INV_GAIN_Q24);
            sb_reg <= in_sb;
        end
    end

    assign out_valid = valid_reg;
    assign out_mag = {1'b0, prod_reg[atrp_pkg::GAIN_SHIFT +: atrp_pkg::DATA_W-1]};
    assign out_sb = sb_reg;

endmodule

// ===== hw/rtl/accel_tilt_roll_pitch_core.sv =====
// top level: roll and pitch from one accelerometer sample
//
// sample channel takes accel_x, accel_y, accel_z as signed 16-bit raw counts;
// result channel gives roll_angle (+-180 deg) and pitch_angle (+-90 deg),
// both in degrees scaled by 2^ANGLE_FRAC_BITS, rounded to nearest
// one request is taken per cycle when the result side keeps up
// the pipeline is two cordic passes of one register per stage plus
// prerotation, one gain multiply and one output rounding stage
// unstalled, throughput is one request per cycle, set by the fully
// pipelined passes; when the receiver stalls a waiting result, the whole
// pipeline holds and sample.ready drops; nothing is lost or repeated
// reset clears all valid bits; the block keeps no other state
// an all-zero sample gives zero roll and zero pitch
module accel_tilt_roll_pitch_core #(
    parameter int CORDIC_STAGES = 16,
    parameter int ANGLE_FRAC_BITS = 6
) (
    input  logic            clk,
    input  logic            rst_n,
    atrp_in_if.sink         sample,
    atrp_out_if.source      result
);

    localparam int SB1_W = atrp_pkg::ACCEL_W;
    localparam int SB2_W = atrp_pkg::ACC_W + atrp_pkg::ACCEL_W;
    localparam int SB3_W = atrp_pkg::ACC_W;

    logic en;
    logic out_valid_reg;
    logic signed [atrp_pkg::ROLL_W-1:0] roll_reg;
    logic signed [atrp_pkg::PITCH_W-1:0] pitch_reg;

    atrp_pkg::data_t p1_x;
    atrp_pkg::data_t p1_y;
    logic p1_valid;
    atrp_pkg::data_t p1_mag;
    atrp_pkg::acc_t p1_acc;
    logic [SB1_W-1:0] p1_sb;

    logic ms_valid;
    atrp_pkg::data_t ms_mag;
    logic [SB2_W-1:0] ms_sb;
    atrp_pkg::data_t p2_y;

    logic p2_valid;
    atrp_pkg::acc_t p2_acc;
    logic [SB3_W-1:0] p2_sb;

    atrp_pkg::acc_t roll_clamp;
    atrp_pkg::acc_t pitch_clamp;
    atrp_pkg::acc_t roll_sum;
    atrp_pkg::acc_t pitch_sum;
    atrp_pkg::acc_t roll_sh;
    atrp_pkg::acc_t pitch_sh;

    assign en = result.ready || !out_valid_reg;
    assign sample.ready = en;

    assign p1_x = atrp_pkg::data_t'(sample.accel_z) <<< atrp_pkg::GUARD_SHIFT;
    assign p1_y = atrp_pkg::data_t'(sample.accel_y) <<< atrp_pkg::GUARD_SHIFT;

    atrp_cordic_vec #(.STAGES(CORDIC_STAGES), .SB_W(SB1_W)) u_pass_roll (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(sample.valid), .in_x(p1_x), .in_y(p1_y), .in_sb(sample.accel_x),
        .out_valid(p1_valid), .out_x(p1_mag), .out_acc(p1_acc), .out_sb(p1_sb)
    );

    atrp_mag_scale #(.SB_W(SB2_W)) u_mag (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(p1_valid), .in_mag(p1_mag), .in_sb({p1_acc, p1_sb}),
        .out_valid(ms_valid), .out_mag(ms_mag), .out_sb(ms_sb)
    );

    assign p2_y = -(atrp_pkg::data_t'($signed(ms_sb[SB1_W-1:0])) <<< atrp_pkg::GUARD_SHIFT);

    atrp_cordic_vec #(.STAGES(CORDIC_STAGES), .SB_W(SB3_W)) u_pass_pitch (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(ms_valid), .in_x(ms_mag), .in_y(p2_y), .in_sb(ms_sb[SB2_W-1:SB1_W]),
        .out_valid(p2_valid), .out_x(), .out_acc(p2_acc), .out_sb(p2_sb)
    );

    // saturate, round half up, scale down
    always_comb
    begin
        roll_clamp = $signed(p2_sb);
        if (roll_clamp > atrp_pkg::DEG180_Q32)
        begin
            roll_clamp = atrp_pkg::DEG180_Q32;
        end
        else if (roll_clamp < -atrp_pkg::DEG180_Q32)
        begin
            roll_clamp = -atrp_pkg::DEG180_Q32;
        end
        pitch_clamp = p2_acc;
        if (pitch_clamp > atrp_pkg::DEG90_Q32)
        begin
            pitch_clamp = atrp_pkg::DEG90_Q32;
        end
        else if (pitch_clamp < -atrp_pkg::DEG90_Q32)
        begin
            pitch_clamp = -atrp_pkg::DEG90_Q32;
        end
        roll_sum = roll_clamp + (atrp_pkg::ACC_W'(1) <<< (31 - ANGLE_FRAC_BITS));
        pitch_sum = pitch_clamp + (atrp_pkg::ACC_W'(1) <<< (31 - ANGLE_FRAC_BITS));
        roll_sh = roll_sum >>> (32 - ANGLE_FRAC_BITS);
        pitch_sh = pitch_sum >>> (32 - ANGLE_FRAC_BITS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= p2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            roll_reg <= roll_sh[atrp_pkg::ROLL_W-1:0];
            pitch_reg <= pitch_sh[atrp_pkg::PITCH_W-1:0];
        end
    end

    assign result.valid = out_valid_reg;
    assign result.roll_angle = roll_reg;
    assign result.pitch_angle = pitch_reg;

endmodule

// ===== sim/tilt_scoreboard.sv =====
// scoreboard class: predicts roll and pitch per sample and checks results
`timescale 1ns / 1ps
class tilt_scoreboard;
    logic [14:0] roll_q[$];
    logic [13:0] pitch_q[$];
    int errors;
    longint angle_tab[64];

    function new();
        errors = 0;
        for (int i = 0; i < 64; i++)
        begin
            angle_tab[i] = atan_deg_q32(i);
        end
    endfunction

    static function longint fshr(longint v, int s);
        if (s > 63)
        begin
            s = 63;
        end
        return v >>> s;
    endfunction

    static function longint atan_deg_q32(int i);
        logic [63:0] sum;
        logic [63:0] term;
        bit minus;
        sum = 0;
        minus = 0;
        if (i == 0)
        begin
            return longint'(64'd45 << 32);
        end
        for (int n = 1; i * n < 62; n += 2)
        begin
            term = (64'd1 << (62 - i * n)) / 64'(n);
            if (minus)
            begin
                sum = sum - term;
            end
            else
            begin
                sum = sum + term;
            end
            minus = !minus;
        end
        return longint'(((sum >> 30) * 64'd3845054675) >> 26);
    endfunction

    function longint vector_angle(longint x, longint y, output longint mag);
        longint acc;
        longint xs;
        longint ys;
        acc = 0;
        if (x == 0 && y == 0)
        begin
            mag = 0;
            return 0;
        end
        if (x < 0)
        begin
            acc = (y >= 0) ? 180 * 64'sd4294967296 : -180 * 64'sd4294967296;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < 16; i++)
        begin
            xs = fshr(x, i);
            ys = fshr(y, i);
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                acc += angle_tab[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                acc -= angle_tab[i];
            end
        end
        mag = x;
        return acc;
    endfunction

    static function longint round_sat(longint ang, longint lim);
        if (ang > lim)
        begin
            ang = lim;
        end
        if (ang < -lim)
        begin
            ang = -lim;
        end
        return fshr(ang + (64'sd1 <<< 25), 26);
    endfunction

    function void note_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                              logic signed [15:0] az);
        longint raw;
        longint dummy;
        longint roll;
        longint pitch;
        longint mag;
        logic [63:0] prod;
        roll = vector_angle(longint'(az) * 1048576, longint'(ay) * 1048576, raw);
        if (raw < 0)
        begin
            raw = 0;
        end
        prod = 64'(raw) * 64'd10188014;
        mag = longint'(prod >> 24);
        pitch = vector_angle(mag, -longint'(ax) * 1048576, dummy);
        roll_q.push_back(15'(round_sat(roll, 180 * 64'sd4294967296)));
        pitch_q.push_back(14'(round_sat(pitch, 90 * 64'sd4294967296)));
    endfunction

    function void check_result(logic [14:0] roll, logic [13:0] pitch);
        logic [14:0] er;
        logic [13:0] ep;
        if (roll_q.size() == 0)
        begin
            $display("%0t unexpected result roll %0d pitch %0d", $time, roll, pitch);
            errors++;
            return;
        end
        er = roll_q.pop_front();
        ep = pitch_q.pop_front();
        if (er !== roll)
        begin
            $display("%0t roll mismatch expected %0d actual %0d", $time,
                     $signed(er), $signed(roll));
            errors++;
        end
        if (ep !== pitch)
        begin
            $display("%0t pitch mismatch expected %0d actual %0d", $time,
                     $signed(ep), $signed(pitch));
            errors++;
        end
    endfunction

    function int pending();
        return roll_q.size();
    endfunction
endclass

// ===== sim/tb_top.sv =====
// testbench top: drives samples into the tilt core and checks the angles
`timescale 1ns / 1ps
module tb_top;

    logic clk;
    logic rst_n;
    bit no_idle;
    atrp_in_if sample();
    atrp_out_if result();
    tilt_scoreboard sb;

    accel_tilt_roll_pitch_core uut (
        .clk(clk),
        .rst_n(rst_n),
        .sample(sample.sink),
        .result(result.source)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    initial
    begin
        sample.valid = 1'b0;
        sample.accel_x = '0;
        sample.accel_y = '0;
        sample.accel_z = '0;
        result.ready = 1'b0;
        sb = new();
    end

    always @(posedge clk)
    begin
        if (rst_n && result.valid && result.ready)
        begin
            sb.check_result(result.roll_angle, result.pitch_angle);
        end
    end

    // receiver stalls in bursts
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!no_idle && $urandom_range(0, 5) == 0)
            begin
                result.ready <= 1'b0;
                n = $urandom_range(1, 16);
                repeat (n - 1) @(posedge clk);
                @(posedge clk);
            end
            result.ready <= 1'b1;
            n = $urandom_range(1, 20);
            repeat (n - 1) @(posedge clk);
        end
    end

    task automatic send_sample(logic [15:0] ax, logic [15:0] ay, logic [15:0] az);
        int n;
        if (!no_idle && $urandom_range(0, 7) == 0)
        begin
            sample.valid <= 1'b0;
            n = $urandom_range(1, 16);
            repeat (n) @(posedge clk);
        end
        sample.valid <= 1'b1;
        sample.accel_x <= ax;
        sample.accel_y <= ay;
        sample.accel_z <= az;
        do
        begin
            @(posedge clk);
        end
        while (!sample.ready);
        sb.note_sample(ax, ay, az);
    endtask

    function automatic logic [15:0] pick_axis();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(int'($urandom_range(0, 8)) - 4);
            3: return 16'(int'($urandom_range(0, 512)) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [15:0] ext[6];
        int k;
        ext = '{16'h8000, 16'h7fff, 16'h0000, 16'h0001, 16'hffff, 16'h4000};
        no_idle = 1'b0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_sample(16'h0000, 16'h0000, 16'h0000);
        send_sample(16'h0000, 16'h0000, 16'h8000);
        send_sample(16'h0000, 16'h0000, 16'h7fff);
        send_sample(16'h0000, 16'hffff, 16'h8000);
        send_sample(16'h0000, 16'h0001, 16'h8000);
        send_sample(16'h8000, 16'h0000, 16'h0000);
        send_sample(16'h7fff, 16'h0000, 16'h0000);
        send_sample(16'h8000, 16'h8000, 16'h8000);
        send_sample(16'h7fff, 16'h7fff, 16'h7fff);
        send_sample(16'h0000, 16'h7fff, 16'h0000);
        send_sample(16'h0000, 16'h8000, 16'h0000);
        for (int i = 0; i < 12; i++)
        begin
            send_sample(ext[$urandom_range(0, 5)], ext[$urandom_range(0, 5)],
                        ext[$urandom_range(0, 5)]);
        end
        for (int i = 0; i < 1030; i++)
        begin
            if (i == 500)
            begin
                sample.valid <= 1'b0;
                k = 0;
                while (sb.pending() != 0 && k < 100000)
                begin
                    @(posedge clk);
                    k++;
                end
            end
            if (i == 850)
            begin
                no_idle = 1'b1;
            end
            send_sample(pick_axis(), pick_axis(), pick_axis());
        end
        sample.valid <= 1'b0;
        k = 0;
        while (sb.pending() != 0 && k < 100000)
        begin
            @(posedge clk);
            k++;
        end
        repeat (40) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end
endmodule

// ===== files.f =====
hw/rtl/atrp_pkg.sv
hw/rtl/atrp_if.sv
hw/rtl/atrp_cordic_vec.sv
hw/rtl/atrp_mag_scale.sv
hw/rtl/accel_tilt_roll_pitch_core.sv
sim/tilt_scoreboard.sv
sim/tb_top.sv
